// ===== rtl/core/tcb_pkg.sv =====
// Shared types, codes and sizes of the character-cell text buffer.
package tcb_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int TAB_STOP    = 8;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COLS_W = COL_W + 1;
    localparam int ROWS_W = ROW_W + 1;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int CELL_W = 16;
    localparam int REP_W  = 8;
    localparam int KEY_W  = 4;
    localparam int OPC_W  = 2;
    localparam int CFG_W  = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'b1;

    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(25);

    localparam logic [CELL_W-1:0] SPACE_CODE   = 16'h0020;
    localparam logic [CELL_W-1:0] CH_BACKSPACE = 16'd8;
    localparam logic [CELL_W-1:0] CH_TAB       = 16'd9;
    localparam logic [CELL_W-1:0] CH_LINEFEED  = 16'd10;
    localparam logic [CELL_W-1:0] CH_RETURN    = 16'd13;
    localparam logic [CELL_W-1:0] CH_ESCAPE    = 16'd27;

    localparam logic [KEY_W-1:0] KEY_HOME   = 4'd0;
    localparam logic [KEY_W-1:0] KEY_END    = 4'd1;
    localparam logic [KEY_W-1:0] KEY_TOP    = 4'd2;
    localparam logic [KEY_W-1:0] KEY_BOTTOM = 4'd3;
    localparam logic [KEY_W-1:0] KEY_LEFT   = 4'd4;
    localparam logic [KEY_W-1:0] KEY_RIGHT  = 4'd5;
    localparam logic [KEY_W-1:0] KEY_UP     = 4'd6;
    localparam logic [KEY_W-1:0] KEY_DOWN   = 4'd7;
    localparam logic [KEY_W-1:0] KEY_DELETE = 4'd8;

    typedef enum logic [OPC_W-1:0] {
        OPC_KEY  = 2'd0,
        OPC_CHAR = 2'd1,
        OPC_READ = 2'd2,
        OPC_NOP  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CC_GLYPH,
        CC_BS,
        CC_TAB,
        CC_LF,
        CC_CR,
        CC_ESC
    } char_class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHAR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_KEY,
        OP_GLYPH,
        OP_SPACE,
        OP_LF,
        OP_CR,
        OP_BS_BACK,
        OP_DEL_START,
        OP_DEL_READ,
        OP_DEL_WRITE,
        OP_DEL_LAST,
        OP_RD_ISSUE,
        OP_CLR_START,
        OP_CLR_STEP,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   dec_rep;
    } dp_cmd_t;

    typedef struct packed {
        logic        cfg_clear;
        logic        clr_last;
        logic        rep_zero;
        opcode_t     opcode;
        logic        key_is_delete;
        char_class_t char_class;
        logic        x_zero;
        logic        tab_done;
        logic        del_more;
    } dp_sts_t;

endpackage

// ===== rtl/core/text_cell_buffer_cursor_editor.sv =====
// Top level of the character-cell text buffer with cursor.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  request  | start / busy       | opcode, key_code, char_code, repeat_count,
//           |                    | read_column, read_row
//  result   | done (one cycle)   | cursor_column, cursor_row, cell_value
//  config   | cfg_we             | cfg_index, cfg_data
//
// A request is taken at an edge with start high and busy low; its result is
// shown for exactly one cycle with done high, and the receiver cannot stall it.
// A read, a key or a no-op passes through dispatch and done; a character request
// takes one step per glyph, space, line feed or return; deletes and backspaces
// shift each cell with a read and a write, then blank the last cell of the row, and
// clear-screen sweeps the 8192-cell store one cell a cycle. Reset and every size
// write start the same sweep with busy high; a write during one restarts it.
module text_cell_buffer_cursor_editor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [tcb_pkg::OPC_W-1:0]     opcode,
    input  logic [tcb_pkg::KEY_W-1:0]     key_code,
    input  logic [tcb_pkg::CELL_W-1:0]    char_code,
    input  logic [tcb_pkg::REP_W-1:0]     repeat_count,
    input  logic [tcb_pkg::COL_W-1:0]     read_column,
    input  logic [tcb_pkg::ROW_W-1:0]     read_row,
    output logic                          done,
    output logic [tcb_pkg::COL_W-1:0]     cursor_column,
    output logic [tcb_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcb_pkg::CELL_W-1:0]    cell_value
);
    import tcb_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequence each request as a string of datapath operations
    tcb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // hold the cell store, cursor and sizes; drive the result registers
    tcb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .opcode        (opcode),
        .key_code      (key_code),
        .char_code     (char_code),
        .repeat_count  (repeat_count),
        .read_column   (read_column),
        .read_row      (read_row),
        .cmd           (cmd),
        .sts           (sts),
        .done          (done),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cell_value    (cell_value)
    );

endmodule

// ===== rtl/core/tcb_ctrl.sv =====
// Sequencer of the text buffer: steps one request through datapath operations.
module tcb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tcb_pkg::dp_sts_t  sts,
    output tcb_pkg::dp_cmd_t  cmd
);
    import tcb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   report_reg;
    logic   report_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd.op      = OP_NONE;
        cmd.dec_rep = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LATCH;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.opcode)
                    OPC_KEY:
                    begin
                        if (sts.key_is_delete)
                        begin
                            cmd.op     = OP_DEL_START;
                            state_next = ST_DEL_RD;
                        end
                        else
                        begin
                            cmd.op     = OP_KEY;
                            state_next = ST_DONE;
                        end
                    end
                    OPC_CHAR: state_next = ST_CHAR;
                    OPC_READ:
                    begin
                        cmd.op     = OP_RD_ISSUE;
                        state_next = ST_DONE;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_CHAR:
            begin
                if (sts.rep_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    case (sts.char_class)
                        CC_ESC:
                        begin
                            // a second clear changes nothing: drop the rest
                            cmd.op      = OP_CLR_START;
                            report_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        CC_BS:
                        begin
                            cmd.dec_rep = 1'b1;
                            if (!sts.x_zero)
                            begin
                                cmd.op     = OP_BS_BACK;
                                state_next = ST_DEL_RD;
                            end
                        end
                        CC_TAB:
                        begin
                            cmd.op      = OP_SPACE;
                            cmd.dec_rep = sts.tab_done;
                        end
                        CC_LF:
                        begin
                            cmd.op      = OP_LF;
                            cmd.dec_rep = 1'b1;
                        end
                        CC_CR:
                        begin
                            cmd.op      = OP_CR;
                            cmd.dec_rep = 1'b1;
                        end
                        default:
                        begin
                            cmd.op      = OP_GLYPH;
                            cmd.dec_rep = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEL_RD:
            begin
                if (sts.del_more)
                begin
                    cmd.op     = OP_DEL_READ;
                    state_next = ST_DEL_WR;
                end
                else
                begin
                    cmd.op     = OP_DEL_LAST;
                    state_next = (sts.opcode == OPC_KEY) ? ST_DONE : ST_CHAR;
                end
            end
            ST_DEL_WR:
            begin
                cmd.op     = OP_DEL_WRITE;
                state_next = ST_DEL_RD;
            end
            ST_CLEAR:
            begin
                cmd.op = OP_CLR_STEP;
                if (sts.clr_last)
                begin
                    state_next  = report_reg ? ST_DONE : ST_IDLE;
                    report_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                cmd.op     = OP_EMIT;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // a size write restarts the wipe and owes no result
        if (sts.cfg_clear)
        begin
            state_next  = ST_CLEAR;
            report_next = 1'b0;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== rtl/core/tcb_dp.sv =====
// Datapath of the text buffer: cell store, cursor, sizes, counters and result registers.
module tcb_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcb_pkg::CFG_W-1:0]     cfg_data,
    input  logic [tcb_pkg::OPC_W-1:0]     opcode,
    input  logic [tcb_pkg::KEY_W-1:0]     key_code,
    input  logic [tcb_pkg::CELL_W-1:0]    char_code,
    input  logic [tcb_pkg::REP_W-1:0]     repeat_count,
    input  logic [tcb_pkg::COL_W-1:0]     read_column,
    input  logic [tcb_pkg::ROW_W-1:0]     read_row,
    input  tcb_pkg::dp_cmd_t              cmd,
    output tcb_pkg::dp_sts_t              sts,
    output logic                          done,
    output logic [tcb_pkg::COL_W-1:0]     cursor_column,
    output logic [tcb_pkg::ROW_W-1:0]     cursor_row,
    output logic [tcb_pkg::CELL_W-1:0]    cell_value
);
    import tcb_pkg::*;

    localparam int STORE_CELLS = MAX_COLUMNS * MAX_ROWS;

    logic [CELL_W-1:0] mem [STORE_CELLS];

    logic [COLS_W-1:0] cols_reg,  cols_next;
    logic [ROWS_W-1:0] rows_reg,  rows_next;
    logic [COL_W-1:0]  cur_x_reg, cur_x_next;
    logic [ROW_W-1:0]  cur_y_reg, cur_y_next;
    logic [COL_W-1:0]  ptr_reg,   ptr_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [REP_W-1:0]  rep_reg,   rep_next;
    logic              done_reg,  done_next;
    opcode_t           opc_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CELL_W-1:0] code_reg;
    logic [COL_W-1:0]  rcol_reg;
    logic [ROW_W-1:0]  rrow_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [CELL_W-1:0] out_val_reg;
    logic [CELL_W-1:0] rdata_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    logic [COLS_W-1:0] x_inc;
    logic [ROWS_W-1:0] y_inc;
    logic [COLS_W-1:0] ptr_inc;
    logic [COLS_W-1:0] cols_dec;
    logic [ROWS_W-1:0] rows_dec;
    logic [ROW_W-1:0]  row_adv;
    logic              glyph_wrap;
    logic [COL_W-1:0]  glyph_x;
    logic [ROW_W-1:0]  glyph_y;
    logic [COLS_W-1:0] cfg_cols;
    logic [ROWS_W-1:0] cfg_rows;
    logic              cfg_hit;
    char_class_t       cls;

    assign x_inc      = {1'b0, cur_x_reg} + COLS_W'(1);
    assign y_inc      = {1'b0, cur_y_reg} + ROWS_W'(1);
    assign ptr_inc    = {1'b0, ptr_reg} + COLS_W'(1);
    assign cols_dec   = cols_reg - COLS_W'(1);
    assign rows_dec   = rows_reg - ROWS_W'(1);
    assign row_adv    = (y_inc >= rows_reg) ? '0 : y_inc[ROW_W-1:0];
    assign glyph_wrap = (x_inc >= cols_reg);
    assign glyph_x    = glyph_wrap ? '0 : x_inc[COL_W-1:0];
    assign glyph_y    = glyph_wrap ? row_adv : cur_y_reg;

    // size writes: zero reads as one, large values saturate; rows use only the low 7 data bits
    always_comb
    begin
        cfg_cols = cfg_data[COLS_W-1:0];
        if (cfg_cols == '0)
            cfg_cols = COLS_W'(1);
        else if (cfg_cols > COLS_W'(MAX_COLUMNS))
            cfg_cols = COLS_W'(MAX_COLUMNS);
        cfg_rows = cfg_data[ROWS_W-1:0];
        if (cfg_rows == '0)
            cfg_rows = ROWS_W'(1);
        else if (cfg_rows > ROWS_W'(MAX_ROWS))
            cfg_rows = ROWS_W'(MAX_ROWS);
    end

    assign cfg_hit = cfg_we && (cfg_index == REG_COLUMNS || cfg_index == REG_ROWS);

    always_comb
    begin
        case (code_reg)
            CH_BACKSPACE: cls = CC_BS;
            CH_TAB:       cls = CC_TAB;
            CH_LINEFEED:  cls = CC_LF;
            CH_RETURN:    cls = CC_CR;
            CH_ESCAPE:    cls = CC_ESC;
            default:      cls = CC_GLYPH;
        endcase
    end

    always_comb
    begin
        cols_next     = cols_reg;
        rows_next     = rows_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        ptr_next      = ptr_reg;
        clr_addr_next = clr_addr_reg;
        rep_next      = rep_reg;
        done_next     = 1'b0;
        we            = 1'b0;
        waddr         = {cur_y_reg, cur_x_reg};
        wdata         = SPACE_CODE;
        re            = 1'b0;
        raddr         = {rrow_reg, rcol_reg};

        case (cmd.op)
            OP_KEY:
            begin
                case (key_reg)
                    KEY_HOME:   cur_x_next = '0;
                    KEY_END:    cur_x_next = cols_dec[COL_W-1:0];
                    KEY_TOP:    cur_y_next = '0;
                    KEY_BOTTOM: cur_y_next = rows_dec[ROW_W-1:0];
                    KEY_LEFT:
                        if (cur_x_reg != '0)
                            cur_x_next = cur_x_reg - COL_W'(1);
                    KEY_RIGHT:
                        if (x_inc < cols_reg)
                            cur_x_next = x_inc[COL_W-1:0];
                    KEY_UP:
                        if (cur_y_reg != '0)
                            cur_y_next = cur_y_reg - ROW_W'(1);
                    KEY_DOWN:
                        if (y_inc < rows_reg)
                            cur_y_next = y_inc[ROW_W-1:0];
                    default: ;
                endcase
            end
            OP_GLYPH, OP_SPACE:
            begin
                we         = 1'b1;
                wdata      = (cmd.op == OP_GLYPH) ? code_reg : SPACE_CODE;
                cur_x_next = glyph_x;
                cur_y_next = glyph_y;
            end
            OP_LF:
                cur_y_next = row_adv;
            OP_CR:
            begin
                cur_x_next = '0;
                cur_y_next = row_adv;
            end
            OP_BS_BACK:
            begin
                cur_x_next = cur_x_reg - COL_W'(1);
                ptr_next   = cur_x_reg - COL_W'(1);
            end
            OP_DEL_START:
                ptr_next = cur_x_reg;
            OP_DEL_READ:
            begin
                re    = 1'b1;
                raddr = {cur_y_reg, ptr_inc[COL_W-1:0]};
            end
            OP_DEL_WRITE:
            begin
                we       = 1'b1;
                waddr    = {cur_y_reg, ptr_reg};
                wdata    = rdata_reg;
                ptr_next = ptr_inc[COL_W-1:0];
            end
            OP_DEL_LAST:
            begin
                we    = 1'b1;
                waddr = {cur_y_reg, cols_dec[COL_W-1:0]};
            end
            OP_RD_ISSUE:
                re = 1'b1;
            OP_CLR_START:
            begin
                clr_addr_next = '0;
                cur_x_next    = '0;
                cur_y_next    = '0;
            end
            OP_CLR_STEP:
            begin
                we            = 1'b1;
                waddr         = clr_addr_reg;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            OP_EMIT:
                done_next = 1'b1;
            default: ;
        endcase

        if (cmd.dec_rep)
            rep_next = rep_reg - REP_W'(1);
        if (cmd.op == OP_LATCH)
            rep_next = repeat_count;

        if (cfg_hit)
        begin
            if (cfg_index == REG_COLUMNS)
                cols_next = cfg_cols;
            else
                rows_next = cfg_rows;
            clr_addr_next = '0;
            cur_x_next    = '0;
            cur_y_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg     <= COLS_RESET;
            rows_reg     <= ROWS_RESET;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            clr_addr_reg <= '0;
            rep_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            clr_addr_reg <= clr_addr_next;
            rep_reg      <= rep_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.op == OP_LATCH)
        begin
            opc_reg  <= opcode_t'(opcode);
            key_reg  <= key_code;
            code_reg <= char_code;
            rcol_reg <= read_column;
            rrow_reg <= read_row;
        end
        if (cmd.op == OP_EMIT)
        begin
            out_col_reg <= cur_x_reg;
            out_row_reg <= cur_y_reg;
            out_val_reg <= (opc_reg == OPC_READ) ? rdata_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        sts.cfg_clear     = cfg_hit;
        sts.clr_last      = (clr_addr_reg == {ADDR_W{1'b1}});
        sts.rep_zero      = (rep_reg == '0);
        sts.opcode        = opc_reg;
        sts.key_is_delete = (key_reg == KEY_DELETE);
        sts.char_class    = cls;
        sts.x_zero        = (cur_x_reg == '0);
        sts.tab_done      = ((glyph_x % COL_W'(TAB_STOP)) == '0);
        sts.del_more      = (ptr_inc < cols_reg);
    end

    assign done          = done_reg;
    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cell_value    = out_val_reg;

endmodule
